[rtl/obrb_pkg.sv]
// ----------------------------------------------------------------------------
// obrb_pkg: shared definitions for the overwriting byte ring buffer
// Operation codes, field widths and the default store depth.
// ----------------------------------------------------------------------------
package obrb_pkg;

  // default number of slots in the byte store
  localparam int unsigned DEPTH_DEFAULT = 64;

  // fixed field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned LEVEL_W = 7;

  // reset value of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_PULL  = 3'd1,
    FUNC_WRITE = 3'd2,
    FUNC_READ  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_t;

endpackage

[rtl/overwrite_byte_ring_buffer_core.sv]
// ----------------------------------------------------------------------------
// overwrite_byte_ring_buffer_core: overwriting byte ring buffer
// Ring buffer of bytes with push, pull, positional read/write and clear.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: an operation (func, data_in, position) is taken at a
//   rising edge with start high and busy low. busy is always low, so one
//   operation can be issued on every clock.
//   Result channel: in the cycle after each operation, done pulses for exactly
//   one cycle with data_out, error, fill_level and is_full. The receiver
//   cannot stall; a result not captured in that cycle is gone.
//   Throughput is one operation per cycle: pointers, valid bits and the store
//   write settle at the command edge, and the byte store's registered read
//   port delivers data with the result.
//   Configuration: cfg_valid/cfg_ready write the capacity register (always
//   ready); each write also clears the buffer. Write it only while idle.
//   Reset: capacity returns to 64, pointers and the wrap flag go to zero and
//   every slot reads as zero. No clearing pass is needed, the valid bits are
//   flip-flops cleared at once.
// ----------------------------------------------------------------------------
module overwrite_byte_ring_buffer_core #(
  parameter int unsigned DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // command transfer
  input  logic                          start,
  output logic                          busy,
  input  logic [obrb_pkg::FUNC_W-1:0]   func,
  input  logic [obrb_pkg::DATA_W-1:0]   data_in,
  input  logic [obrb_pkg::POS_W-1:0]    position,
  // result transfer
  output logic                          done,
  output logic [obrb_pkg::DATA_W-1:0]   data_out,
  output logic                          error,
  output logic [obrb_pkg::LEVEL_W-1:0]  fill_level,
  output logic                          is_full,
  // capacity register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [obrb_pkg::CAP_W-1:0]    capacity
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // arithmetic width: holds DEPTH, capacity and any pointer sum
  localparam int unsigned LW = ((PW > obrb_pkg::CAP_W) ? PW : obrb_pkg::CAP_W) + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  // state
  logic [obrb_pkg::CAP_W-1:0]  cap_reg;
  logic [PW-1:0]               wp;
  logic [PW-1:0]               rp;
  logic                        wrap;
  logic [DEPTH-1:0]            slot_valid;
  logic [obrb_pkg::DATA_W-1:0] store [DEPTH];

  // result stage
  logic [obrb_pkg::DATA_W-1:0] rd_data;
  logic                        rd_valid;
  logic                        rd_sel;

  // next values
  logic [PW-1:0]               wp_next;
  logic [PW-1:0]               rp_next;
  logic                        wrap_next;
  logic [PW-1:0]               addr;
  logic                        wr_en;
  logic                        vld_clr;
  logic                        clr_all;
  logic                        err_next;
  logic                        sel_next;
  logic [LW-1:0]               level_next;

  logic                        accept;
  logic                        cfg_write;
  logic [LW-1:0]               cap_eff;
  logic [LW-1:0]               wp_inc;
  logic [LW-1:0]               rp_inc;
  logic [LW-1:0]               slot_sum;
  logic [LW-1:0]               slot_idx;
  logic                        pos_ok;
  logic                        empty;
  logic                        full;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // capacity in use: zero acts as one, clamp at the store depth
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = LW'(1);
    end else if (LW'(cap_reg) > DEPTH_L) begin
      cap_eff = DEPTH_L;
    end else begin
      cap_eff = LW'(cap_reg);
    end
  end

  // pointer arithmetic and slot addressing
  always_comb begin
    wp_inc   = LW'(wp) + LW'(1);
    rp_inc   = LW'(rp) + LW'(1);
    pos_ok   = LW'(position) < cap_eff;
    slot_sum = LW'(rp) + LW'(position);
    if (slot_sum >= cap_eff) begin
      slot_idx = slot_sum - cap_eff;
    end else begin
      slot_idx = slot_sum;
    end
    if (slot_idx >= DEPTH_L) begin
      slot_idx = '0;
    end
    empty = !wrap && (wp == rp);
    full  = wrap && (wp == rp);
  end

  // operation decode
  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    wrap_next = wrap;
    addr      = wp;
    wr_en     = 1'b0;
    vld_clr   = 1'b0;
    clr_all   = 1'b0;
    err_next  = 1'b0;
    sel_next  = 1'b0;
    unique case (func)
      obrb_pkg::FUNC_PUSH: begin
        wr_en = 1'b1;
        if (full) begin
          rp_next = (rp_inc >= cap_eff) ? '0 : rp_inc[PW-1:0];
        end
        if (wp_inc >= cap_eff) begin
          wp_next   = '0;
          wrap_next = 1'b1;
        end else begin
          wp_next = wp_inc[PW-1:0];
        end
      end
      obrb_pkg::FUNC_PULL: begin
        addr = rp;
        if (empty) begin
          err_next = 1'b1;
        end else begin
          sel_next = 1'b1;
          vld_clr  = 1'b1;
          if (rp_inc >= cap_eff) begin
            rp_next   = '0;
            wrap_next = 1'b0;
          end else begin
            rp_next = rp_inc[PW-1:0];
          end
        end
      end
      obrb_pkg::FUNC_WRITE: begin
        addr = slot_idx[PW-1:0];
        if (pos_ok) begin
          wr_en = 1'b1;
        end else begin
          err_next = 1'b1;
        end
      end
      obrb_pkg::FUNC_READ: begin
        addr = slot_idx[PW-1:0];
        if (pos_ok) begin
          sel_next = 1'b1;
        end else begin
          err_next = 1'b1;
        end
      end
      obrb_pkg::FUNC_CLEAR: begin
        clr_all   = 1'b1;
        wp_next   = '0;
        rp_next   = '0;
        wrap_next = 1'b0;
      end
      default: begin
      end
    endcase
    // fill level after the operation
    level_next = (wrap_next ? cap_eff : '0) + LW'(wp_next) - LW'(rp_next);
  end

  // control state: pointers, wrap flag, valid bits, capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg    <= obrb_pkg::CAP_RESET;
      wp         <= '0;
      rp         <= '0;
      wrap       <= 1'b0;
      slot_valid <= '0;
    end else if (cfg_write) begin
      cap_reg    <= capacity;
      wp         <= '0;
      rp         <= '0;
      wrap       <= 1'b0;
      slot_valid <= '0;
    end else if (accept) begin
      wp   <= wp_next;
      rp   <= rp_next;
      wrap <= wrap_next;
      if (clr_all) begin
        slot_valid <= '0;
      end else if (wr_en) begin
        slot_valid[addr] <= 1'b1;
      end else if (vld_clr) begin
        slot_valid[addr] <= 1'b0;
      end
    end
  end

  // byte store write port
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[addr] <= data_in;
    end
  end

  // byte store read port, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
    if (accept) begin
      rd_valid   <= slot_valid[addr];
      rd_sel     <= sel_next;
      error      <= err_next;
      fill_level <= level_next[obrb_pkg::LEVEL_W-1:0];
      is_full    <= (level_next == cap_eff);
    end
  end

  assign data_out = (rd_sel && rd_valid) ? rd_data : '0;

`ifndef NO_ASSERTIONS
  // every accepted command gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_write |=> done)
    else $error("result strobe missing after command transfer");

  // an errored operation never returns a byte
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    done && error |-> data_out == '0)
    else $error("data returned on errored operation");

  // without a wrap the write pointer never trails the read pointer
  a_pointer_order: assert property (@(posedge clk) disable iff (rst)
    !wrap |-> wp >= rp)
    else $error("write pointer behind read pointer without wrap");

  // pointers stay within the capacity in use
  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    LW'(wp) < cap_eff && LW'(rp) < cap_eff)
    else $error("pointer beyond capacity");
`endif

endmodule
